/* hdl/ssqt_pkg.sv */
// ---------------------------------------------------------------------------
// ssqt_pkg
// Shared types and constants for the single-server queue tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package ssqt_pkg;

	// Default FIFO slot count (one slot always stays empty)
	localparam int SSQT_DEPTH = 16;

	localparam int ID_W    = 16;
	localparam int TICK_W  = 16;
	localparam int SVC_W   = 4;
	localparam int CNT_W   = 4;
	localparam int TOTAL_W = 32;

	// One waiting customer as stored in the FIFO
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TICK_W-1:0] arrival;
		logic [SVC_W-1:0]  service;
	} entry_t;

	// Result of one tick
	typedef struct packed {
		logic               started;
		logic [ID_W-1:0]    started_id;
		logic [TICK_W-1:0]  wait_ticks;
		logic [ID_W-1:0]    assigned_id;
		logic               overflow;
		logic               busy_res;
		logic [ID_W-1:0]    serving_id;
		logic [CNT_W-1:0]   queue_count;
		logic [TOTAL_W-1:0] accum_wait;
	} result_t;

endpackage

`default_nettype wire

/* hdl/single_server_queue_tracker.sv */
// ---------------------------------------------------------------------------
// single_server_queue_tracker
// Single-server waiting-line tracker with a circular FIFO, one tick per
// transaction.
// ---------------------------------------------------------------------------
// Usage:
//   Each input transaction (in_valid/in_ready) is one clock tick of the model,
//   optionally carrying an arrival and its service length. Each input
//   transaction yields exactly one result transaction (out_valid/out_ready).
//   The input register feeds the tick logic, which feeds the result register.
//   Throughput is one transaction per cycle unless the receiver stalls;
//   the tick logic's state (pointers, countdown, counters) updates once per
//   transaction; the FIFO head is prefetched from the registered RAM read port.
//   The FIFO holds DEPTH-1 customers; an arrival into a full FIFO is dropped
//   and flagged with overflow.
//   Reset clears pointers, counters and the wait total; FIFO contents are
//   not cleared and no clearing pass is needed.
//   When the receiver stalls, the result register holds, the input register
//   fills, and in_ready drops until the result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module single_server_queue_tracker
	import ssqt_pkg::*;
#(
	parameter int DEPTH = SSQT_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               arrival_valid,
	input  wire logic [SVC_W-1:0]   new_service_time,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    started,
	output logic      [ID_W-1:0]    started_id,
	output logic      [TICK_W-1:0]  wait_ticks,
	output logic      [ID_W-1:0]    assigned_id,
	output logic                    overflow,
	output logic                    busy_res,
	output logic      [ID_W-1:0]    serving_id,
	output logic      [CNT_W-1:0]   queue_count,
	output logic      [TOTAL_W-1:0] accum_wait
);

	logic             valid_s1;
	logic             arrival_s1;
	logic [SVC_W-1:0] svc_s1;
	logic             valid_s2;
	result_t          result_s2;
	result_t          tick_res;
	logic             adv_s2;
	logic             fire;

	// Pipeline flow control
	assign adv_s2   = !valid_s2 || out_ready;
	assign fire     = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			arrival_s1 <= arrival_valid;
			svc_s1     <= new_service_time;
		end
	end

	// Tick logic
	ssqt_core #(
		.DEPTH (DEPTH)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (fire),
		.arrival_valid    (arrival_s1),
		.new_service_time (svc_s1),
		.result           (tick_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= tick_res;
		end
	end

	assign out_valid   = valid_s2;
	assign started     = result_s2.started;
	assign started_id  = result_s2.started_id;
	assign wait_ticks  = result_s2.wait_ticks;
	assign assigned_id = result_s2.assigned_id;
	assign overflow    = result_s2.overflow;
	assign busy_res    = result_s2.busy_res;
	assign serving_id  = result_s2.serving_id;
	assign queue_count = result_s2.queue_count;
	assign accum_wait  = result_s2.accum_wait;

endmodule

`default_nettype wire

/* hdl/ssqt_ram.sv */
// ---------------------------------------------------------------------------
// ssqt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ssqt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* hdl/ssqt_core.sv */
// ---------------------------------------------------------------------------
// ssqt_core
// Tick logic: FIFO push, server countdown or pop, wait total, and the
// prefetched head entry that feeds the pop path.
// ---------------------------------------------------------------------------
`default_nettype none

module ssqt_core
	import ssqt_pkg::*;
#(
	parameter int DEPTH = SSQT_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire logic             arrival_valid,
	input  wire logic [SVC_W-1:0] new_service_time,
	output result_t               result
);

	localparam int PTR_W = $clog2(DEPTH);

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	// State registers
	logic [PTR_W-1:0]   rp_q, wp_q;
	logic [SVC_W-1:0]   rem_q;
	logic [ID_W-1:0]    cur_q;
	logic [ID_W-1:0]    next_id_q;
	logic [TICK_W-1:0]  tick_q;
	logic [TOTAL_W-1:0] sum_q;

	// Head prefetch
	logic               byp_q;
	entry_t             byp_data_q;
	entry_t             ram_rdata;
	entry_t             head;
	entry_t             new_entry;
	entry_t             pop_entry;

	logic [PTR_W-1:0]   wslot, rslot, wp_n, rp_n, rp_d, raddr;
	logic               full, push, busy, pop, was_empty, we;
	logic [SVC_W-1:0]   rem_n;
	logic [ID_W-1:0]    cur_n;
	logic [TICK_W-1:0]  wait_t;
	logic [TOTAL_W:0]   sum_wide;
	logic [TOTAL_W-1:0] sum_n;
	logic [PTR_W:0]     diff;
	logic [PTR_W:0]     cnt;
	logic [31:0]        cnt32;

	// Push side: arrival is handled before the server
	assign wslot     = adv(wp_q);
	assign full      = (wslot == rp_q);
	assign push      = arrival_valid && !full;
	assign wp_n      = push ? wslot : wp_q;
	assign was_empty = (rp_q == wp_q);

	assign new_entry.id      = next_id_q;
	assign new_entry.arrival = tick_q;
	assign new_entry.service = new_service_time;

	// Server side: count down or pop the oldest entry
	assign busy      = (rem_q != '0);
	assign pop       = !busy && (rp_q != wp_n);
	assign rslot     = adv(rp_q);
	assign rp_n      = pop ? rslot : rp_q;
	assign head      = byp_q ? byp_data_q : ram_rdata;
	// An arrival into an empty queue is popped straight from the input
	assign pop_entry = was_empty ? new_entry : head;

	always_comb begin
		if (busy) begin
			rem_n = rem_q - SVC_W'(1);
		end else if (pop) begin
			rem_n = pop_entry.service;
		end else begin
			rem_n = rem_q;
		end
	end

	assign cur_n    = pop ? pop_entry.id : cur_q;
	assign wait_t   = tick_q - pop_entry.arrival;
	assign sum_wide = {1'b0, sum_q} + (TOTAL_W + 1)'(wait_t);
	assign sum_n    = !pop ? sum_q :
	                  (sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0]);

	// Occupancy after the tick
	always_comb begin
		diff = {1'b0, wp_n} - {1'b0, rp_n};
		if (wp_n < rp_n) begin
			cnt = diff + (PTR_W + 1)'(DEPTH);
		end else begin
			cnt = diff;
		end
	end
	assign cnt32 = 32'(cnt);

	// Result of the tick
	always_comb begin
		result.started     = pop;
		result.started_id  = pop ? pop_entry.id : '0;
		result.wait_ticks  = pop ? wait_t : '0;
		result.assigned_id = push ? next_id_q : '0;
		result.overflow    = arrival_valid && full;
		result.busy_res    = busy;
		result.serving_id  = cur_n;
		result.queue_count = cnt32[CNT_W-1:0];
		result.accum_wait  = sum_n;
	end

	// State update, one tick per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q      <= '0;
			wp_q      <= '0;
			rem_q     <= '0;
			cur_q     <= '0;
			next_id_q <= '0;
			tick_q    <= '0;
			sum_q     <= '0;
		end else if (fire) begin
			rp_q      <= rp_n;
			wp_q      <= wp_n;
			rem_q     <= rem_n;
			cur_q     <= cur_n;
			next_id_q <= push ? next_id_q + ID_W'(1) : next_id_q;
			tick_q    <= tick_q + TICK_W'(1);
			sum_q     <= sum_n;
		end
	end

	// FIFO storage; read address always tracks the slot after the head pointer
	assign we    = fire && push;
	assign rp_d  = fire ? rp_n : rp_q;
	assign raddr = adv(rp_d);

	ssqt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wslot),
		.wdata (new_entry),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// Same-cycle write to the prefetched slot: keep the written data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= we && (wslot == raddr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= new_entry;
	end

endmodule

`default_nettype wire

/* hdl/ssqt_checker.sv */
// ---------------------------------------------------------------------------
// ssqt_checker
// Port-level checks on the queue tracker's result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module ssqt_checker
	import ssqt_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               started,
	input wire logic [ID_W-1:0]    started_id,
	input wire logic [TICK_W-1:0]  wait_ticks,
	input wire logic [ID_W-1:0]    assigned_id,
	input wire logic               overflow,
	input wire logic               busy_res,
	input wire logic [ID_W-1:0]    serving_id,
	input wire logic [TOTAL_W-1:0] accum_wait
);

	// Stalled result transaction holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(accum_wait) && $stable(serving_id))
		else $error("result changed while stalled");

	// A busy server never starts a customer on the same tick
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(started && busy_res))
		else $error("start while busy");

	// No start: start fields read zero
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !started |-> started_id == '0 && wait_ticks == '0)
		else $error("start fields set without start");

	// A started customer becomes the one being served
	a_serving: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && started |-> serving_id == started_id)
		else $error("serving id differs from started id");

	// A dropped arrival gets no id
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> assigned_id == '0)
		else $error("id assigned to dropped arrival");

endmodule

bind single_server_queue_tracker ssqt_checker u_ssqt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.started     (started),
	.started_id  (started_id),
	.wait_ticks  (wait_ticks),
	.assigned_id (assigned_id),
	.overflow    (overflow),
	.busy_res    (busy_res),
	.serving_id  (serving_id),
	.accum_wait  (accum_wait)
);

`default_nettype wire
